FILE: hdl/rvs_pkg.sv
package rvs_pkg;

	// field and datapath widths
	localparam int unsigned SAMPLE_W  = 24;
	localparam int unsigned COUNT_W   = 16;
	localparam int unsigned SUM_W     = 40;
	localparam int unsigned SQSUM_W   = 64;
	localparam int unsigned PROD_W    = 80;
	localparam int unsigned DEN_W     = 32;
	localparam int unsigned DVD_W     = 112;
	localparam int unsigned ROOT_W    = DVD_W / 2;
	localparam int unsigned VALUE_W   = 63;
	localparam int unsigned STEP_W    = 7;

	// parameter defaults
	localparam int unsigned SAMPLE_BITS_DEF   = 24;
	localparam int unsigned COUNT_LIMIT_DEF   = 65535;
	localparam int unsigned FRACTION_BITS_DEF = 16;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_QUERY  = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ACC,
		ST_CLR,
		ST_QRY,
		ST_NQ,
		ST_SSI,
		ST_SS,
		ST_DIFF,
		ST_DIVI,
		ST_DIV,
		ST_SQI,
		ST_SQ,
		ST_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic cap;
		logic acc_apply;
		logic clr;
		logic q_start;
		logic nq_step;
		logic ss_init;
		logic ss_step;
		logic diff;
		logic div_init;
		logic div_step;
		logic sqrt_init;
		logic sqrt_step;
		logic out_load;
	} rvs_cmd_t;

	// datapath to controller
	typedef struct packed {
		op_t  op;
		logic is_null;
		logic dev_kind;
		logic step_last;
		logic out_busy;
	} rvs_sts_t;

endpackage

FILE: hdl/rvs_ctrl.sv
module rvs_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  rvs_pkg::rvs_sts_t sts,
	output rvs_pkg::rvs_cmd_t cmd
);
	import rvs_pkg::*;

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.cap = 1'b1;
					state_d = ST_DIFF;
				end
			end
			ST_ACC: begin
				cmd.acc_apply = 1'b1;
				state_d = ST_IDLE;
			end
			ST_CLR: begin
				cmd.clr = 1'b1;
				state_d = ST_IDLE;
			end
			ST_QRY: begin
				cmd.q_start = 1'b1;
				state_d = ST_NQ;
			end
			ST_NQ: begin
				cmd.nq_step = 1'b1;
				if (sts.step_last) state_d = ST_SSI;
			end
			ST_SSI: begin
				cmd.ss_init = 1'b1;
				state_d = ST_SS;
			end
			ST_SS: begin
				cmd.ss_step = 1'b1;
				if (sts.step_last) state_d = ST_DIVI;
			end
			ST_DIFF: begin
				// captured word is decoded here
				unique case (sts.op) inside
					OP_ADD, OP_REMOVE: state_d = sts.is_null ? ST_IDLE : ST_ACC;
					OP_QUERY:          state_d = ST_QRY;
					OP_CLEAR:          state_d = ST_CLR;
					default:           state_d = ST_IDLE;
				endcase
			end
			ST_DIVI: begin
				cmd.diff = 1'b1;
				state_d = ST_SQI;
			end
			ST_SQI: begin
				// numerator and denominator ready, load divider
				cmd.div_init = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.step_last) state_d = sts.dev_kind ? ST_SQ : ST_OUT;
				if (sts.step_last && sts.dev_kind) cmd.sqrt_init = 1'b1;
			end
			ST_SQ: begin
				cmd.sqrt_step = 1'b1;
				if (sts.step_last) state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

FILE: hdl/rvs_dp.sv
module rvs_dp #(
	parameter int unsigned SAMPLE_BITS   = rvs_pkg::SAMPLE_BITS_DEF,
	parameter int unsigned COUNT_LIMIT   = rvs_pkg::COUNT_LIMIT_DEF,
	parameter int unsigned FRACTION_BITS = rvs_pkg::FRACTION_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_wdata,
	input  logic [rvs_pkg::SAMPLE_W-1:0]  in_sample,
	input  logic [1:0]                    in_op,
	input  logic                          in_null,
	input  rvs_pkg::rvs_cmd_t             cmd,
	output rvs_pkg::rvs_sts_t             sts,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [rvs_pkg::VALUE_W-1:0]   out_value,
	output logic                          out_present,
	output logic [rvs_pkg::COUNT_W-1:0]   out_count,
	output logic                          out_error
);
	import rvs_pkg::*;

	localparam logic [COUNT_W-1:0] LIMIT = COUNT_W'(COUNT_LIMIT);
	localparam int unsigned SH_VAR = FRACTION_BITS;
	localparam int unsigned SH_DEV = 2 * FRACTION_BITS;

	logic [1:0]                 kind_q;
	op_t                        op_q;
	logic                       null_q;
	logic signed [SAMPLE_W-1:0] v_q;
	logic [2*SAMPLE_W-1:0]      sq_q;
	logic [COUNT_W-1:0]         count_q;
	logic [SUM_W-1:0]           sum_q;
	logic [SQSUM_W-1:0]         sqsum_q;
	logic                       flag_q;
	logic [COUNT_W-1:0]         res_count_q;
	logic                       res_flag_q;
	logic                       present_q;
	logic                       sample_kind_q;
	logic                       dev_kind_q;
	logic [STEP_W-1:0]          step_q;
	logic [PROD_W-1:0]          acc_q;
	logic [PROD_W-1:0]          mcand_q;
	logic [SUM_W-1:0]           mplier_q;
	logic [SUM_W-1:0]           mag_hold_q;
	logic [PROD_W-1:0]          nq_q;
	logic [PROD_W-1:0]          num_q;
	logic [DEN_W-1:0]           den_q;
	logic [DVD_W-1:0]           dvd_q;
	logic [DEN_W-1:0]           rem_q;
	logic [ROOT_W-1:0]          root_q;
	logic [ROOT_W:0]            srem_q;

	logic signed [SAMPLE_BITS-1:0] s_low;
	logic signed [SAMPLE_W-1:0]    v_ext;
	logic [SUM_W-1:0]              v_sum;
	logic [SUM_W-1:0]              mag;
	logic                          pres_now;
	logic [COUNT_W-1:0]            n_m1;
	logic [DEN_W:0]                r2;
	logic                          qbit;
	logic [ROOT_W+2:0]             srem2;
	logic [ROOT_W+2:0]             trial;
	logic [VALUE_W-1:0]            var_val;

	// sample sign extension from its low bits
	assign s_low = in_sample[SAMPLE_BITS-1:0];
	assign v_ext = SAMPLE_W'(s_low);
	assign v_sum = SUM_W'(v_q);

	assign mag      = sum_q[SUM_W-1] ? (~sum_q + SUM_W'(1)) : sum_q;
	assign pres_now = kind_q[0] ? (count_q != '0) : (count_q > COUNT_W'(1));
	assign n_m1     = sample_kind_q ? (res_count_q - COUNT_W'(1)) : res_count_q;

	// divider and root step logic
	assign r2    = {rem_q, dvd_q[DVD_W-1]};
	assign qbit  = (r2 >= {1'b0, den_q});
	assign srem2 = {srem_q, dvd_q[DVD_W-1 -: 2]};
	assign trial = {1'b0, root_q, 2'b01};

	assign var_val = (dvd_q[DVD_W-1:VALUE_W] != '0) ? '1 : dvd_q[VALUE_W-1:0];

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= '0;
		end else if (cfg_we) begin
			kind_q <= cfg_wdata;
		end
	end

	// captured word and its square
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			op_q   <= op_t'(in_op);
			null_q <= in_null;
			v_q    <= v_ext;
			sq_q   <= (2*SAMPLE_W)'(v_ext) * (2*SAMPLE_W)'(v_ext);
		end
	end

	// accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
			sqsum_q <= '0;
			flag_q  <= 1'b0;
		end else if (cmd.clr) begin
			count_q <= '0;
			sum_q   <= '0;
			sqsum_q <= '0;
			flag_q  <= 1'b0;
		end else if (cmd.q_start) begin
			flag_q <= 1'b0;
		end else if (cmd.acc_apply) begin
			if (op_q == OP_ADD) begin
				if (count_q >= LIMIT) begin
					flag_q <= 1'b1;
				end else begin
					count_q <= count_q + COUNT_W'(1);
					sum_q   <= sum_q + v_sum;
					sqsum_q <= sqsum_q + SQSUM_W'(sq_q);
				end
			end else begin
				if (count_q == '0) begin
					flag_q <= 1'b1;
				end else begin
					count_q <= count_q - COUNT_W'(1);
					sum_q   <= sum_q - v_sum;
					sqsum_q <= sqsum_q - SQSUM_W'(sq_q);
				end
			end
		end
	end

	// query arithmetic: shift-add multiplier, restoring divider and root
	always_ff @(posedge clk) begin
		if (cmd.q_start) begin
			res_count_q   <= count_q;
			res_flag_q    <= flag_q;
			present_q     <= pres_now;
			sample_kind_q <= ~kind_q[0];
			dev_kind_q    <= kind_q[1];
			acc_q         <= '0;
			mcand_q       <= PROD_W'(sqsum_q);
			mplier_q      <= SUM_W'(count_q);
			step_q        <= STEP_W'(COUNT_W - 1);
			mag_hold_q    <= mag;
		end
		if (cmd.nq_step || cmd.ss_step) begin
			if (mplier_q[0]) acc_q <= acc_q + mcand_q;
			mcand_q  <= {mcand_q[PROD_W-2:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[SUM_W-1:1]};
			step_q   <= step_q - STEP_W'(1);
		end
		if (cmd.ss_init) begin
			nq_q     <= acc_q;
			acc_q    <= '0;
			mcand_q  <= PROD_W'(mag_hold_q);
			mplier_q <= mag_hold_q;
			step_q   <= STEP_W'(SUM_W - 1);
		end
		if (cmd.diff) begin
			num_q <= (nq_q > acc_q) ? (nq_q - acc_q) : '0;
			den_q <= DEN_W'(res_count_q) * DEN_W'(n_m1);
		end
		if (cmd.div_init) begin
			dvd_q  <= dev_kind_q ? (DVD_W'(num_q) << SH_DEV) : (DVD_W'(num_q) << SH_VAR);
			rem_q  <= '0;
			step_q <= STEP_W'(DVD_W - 1);
		end
		if (cmd.div_step) begin
			rem_q  <= qbit ? DEN_W'(r2 - {1'b0, den_q}) : DEN_W'(r2);
			dvd_q  <= {dvd_q[DVD_W-2:0], qbit};
			step_q <= (step_q == '0) ? STEP_W'(ROOT_W - 1) : (step_q - STEP_W'(1));
		end
		if (cmd.sqrt_init) begin
			root_q <= '0;
			srem_q <= '0;
		end
		if (cmd.sqrt_step) begin
			if (srem2 >= trial) begin
				srem_q <= (ROOT_W+1)'(srem2 - trial);
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				srem_q <= (ROOT_W+1)'(srem2);
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
			dvd_q  <= {dvd_q[DVD_W-3:0], 2'b00};
			step_q <= step_q - STEP_W'(1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_present <= present_q;
			out_count   <= res_count_q;
			out_error   <= res_flag_q;
			if (!present_q) out_value <= '0;
			else if (dev_kind_q) out_value <= VALUE_W'(root_q);
			else out_value <= var_val;
		end
	end

	// status
	assign sts.op        = op_q;
	assign sts.is_null   = null_q;
	assign sts.dev_kind  = dev_kind_q;
	assign sts.step_last = (step_q == '0);
	assign sts.out_busy  = out_valid && !out_ready;

endmodule

FILE: hdl/running_variance_stddev_unit.sv
// channel   | direction | words
// s_axis    | in        | tdata[23:0] sample_value; tuser {sample_is_null, operation}
// m_axis    | out       | tdata {count_error, sample_count, statistic_value}; tuser present
// cfg       | in        | cfg_we with cfg_wdata = statistic_kind
//
// add or remove passes capture, decode and accumulate, a null one capture and decode,
// clear capture, decode and clear, all set by the control sequence; a query runs a 16 and a
// 40 step shift-add multiply, a 112 step restoring divide and for deviation a 56 step root
// an absent result skips none of the steps; the value is forced to zero
// reset clears accumulators, configuration and the output valid flag at once
// a stalled output holds the finished word; no input word is taken until it is loaded
module running_variance_stddev_unit #(
	parameter int unsigned SAMPLE_BITS   = rvs_pkg::SAMPLE_BITS_DEF,
	parameter int unsigned COUNT_LIMIT   = rvs_pkg::COUNT_LIMIT_DEF,
	parameter int unsigned FRACTION_BITS = rvs_pkg::FRACTION_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // sample_value
	input  logic [2:0]  s_tuser,  // operation, sample_is_null
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,  // statistic_value, sample_count, count_error
	output logic        m_tuser   // statistic_present
);
	import rvs_pkg::*;

	rvs_cmd_t cmd;
	rvs_sts_t sts;
	logic [VALUE_W-1:0] value;
	logic [COUNT_W-1:0] count;
	logic               err;

	rvs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rvs_dp #(
		.SAMPLE_BITS   (SAMPLE_BITS),
		.COUNT_LIMIT   (COUNT_LIMIT),
		.FRACTION_BITS (FRACTION_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_sample   (s_tdata),
		.in_op       (s_tuser[1:0]),
		.in_null     (s_tuser[2]),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_value   (value),
		.out_present (m_tuser),
		.out_count   (count),
		.out_error   (err)
	);

	assign m_tdata = {err, count, value};

	// a query holds off the input side while it computes
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser[1:0] == OP_QUERY |=> !s_tready)
		else $error("input taken during query");

	// an absent statistic carries a zero value
	a_absent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[62:0] == '0)
		else $error("absent result with nonzero value");

	// a present statistic needs at least one sample
	a_present_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[78:63] != '0)
		else $error("present result with empty count");

endmodule
